// ===== rtl/peripheral_interface_adapter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interface adapter RTL.
// ----------------------------------------------------------------------------
`ifndef PERIPHERAL_INTERFACE_ADAPTER_CORE_ASSERT_SVH
`define PERIPHERAL_INTERFACE_ADAPTER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PIA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define PIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/pia_pkg.sv =====
// ----------------------------------------------------------------------------
// pia_pkg
// Item types, codes and constants of the peripheral interface adapter.
// ----------------------------------------------------------------------------
`default_nettype none

package pia_pkg;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_PIN_A  = 2'd2;
    localparam logic [1:0] OP_PIN_B  = 2'd3;

    localparam logic [1:0] SEL_PORT_A = 2'd0;
    localparam logic [1:0] SEL_PORT_B = 2'd1;
    localparam logic [1:0] SEL_CTL_A  = 2'd2;
    localparam logic [1:0] SEL_CTL_B  = 2'd3;

    localparam logic [2:0] MODE_IN_FALL    = 3'd0;
    localparam logic [2:0] MODE_IN_FALL_EN = 3'd1;
    localparam logic [2:0] MODE_IN_RISE    = 3'd2;
    localparam logic [2:0] MODE_IN_RISE_EN = 3'd3;
    localparam logic [2:0] MODE_HANDSHAKE  = 3'd4;
    localparam logic [2:0] MODE_PULSE      = 3'd5;
    localparam logic [2:0] MODE_OUT_LOW    = 3'd6;
    localparam logic [2:0] MODE_OUT_HIGH   = 3'd7;

    localparam logic [7:0] CTL_RESET   = 8'h3f;
    localparam logic [7:0] CTL_WRITABLE = 8'h3f;
    localparam logic [7:0] CTL_FLAGS   = 8'hc0;
    localparam logic [7:0] FLAG_PIN1   = 8'h80;
    localparam logic [7:0] FLAG_PIN2   = 8'h40;
    localparam logic [7:0] IRQ2_MASK   = 8'h28;
    localparam logic [7:0] IRQ2_MATCH  = 8'h08;
    localparam logic [7:0] PORT_RESET  = 8'hff;
    localparam int         BIT_ENABLE  = 0;
    localparam int         BIT_SELECT  = 2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic       quiet_read;
        logic       pin_level;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       ca2_level;
        logic       cb2_level;
        logic       ca2_pulse;
        logic       cb2_pulse;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/pia_if.sv =====
// ----------------------------------------------------------------------------
// pia_if
// Valid/ready channels carrying adapter items in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pia_in_if;
    logic               valid;
    logic               ready;
    pia_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pia_out_if;
    logic               valid;
    logic               ready;
    pia_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/peripheral_interface_adapter_core.sv =====
// ----------------------------------------------------------------------------
// peripheral_interface_adapter_core
// Two-port parallel interface adapter: bus accesses and CA1/CB1 pin events.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    pia_pkg::in_item_t
//  out_ch    out   valid/ready    pia_pkg::out_item_t
//  cfg       in    cfg_wr_en      cfg_wr_data (machine_is_xlxe)
//
//  One item per cycle while out_ch takes results; its result appears in the cycle after acceptance.
//  State updates in the accepting cycle, result held in one output register.
//  in_ch.ready is high while the output register is empty or being taken.
//  Reset: all adapter state to power-on values, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "peripheral_interface_adapter_core_assert.svh"

module peripheral_interface_adapter_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    pia_in_if.sink      in_ch,
    pia_out_if.source   out_ch
);

    typedef struct packed {
        logic [7:0] ctl;
        logic       pin1;
        logic       line;
        logic       fall;
        logic       rise;
    } side_t;

    localparam side_t SIDE_RESET = '{ctl: pia_pkg::CTL_RESET, pin1: 1'b0,
                                     line: 1'b1, fall: 1'b0, rise: 1'b0};

    function automatic logic ctl_irq(input logic [7:0] c);
        logic r;
        r = ((c & pia_pkg::FLAG_PIN2) != 8'h00 &&
             (c & pia_pkg::IRQ2_MASK) == pia_pkg::IRQ2_MATCH) ||
            (c[7] && c[pia_pkg::BIT_ENABLE]);
        return r;
    endfunction

    function automatic side_t write_control(input side_t s, input logic [7:0] data,
                                            input logic is_b);
        side_t      r;
        logic [7:0] d;
        r     = s;
        d     = data & pia_pkg::CTL_WRITABLE;
        r.ctl = (s.ctl & pia_pkg::CTL_FLAGS) | d;
        case (d[5:3])
            pia_pkg::MODE_IN_FALL, pia_pkg::MODE_IN_FALL_EN:
            begin
                if (s.fall || (is_b && s.rise))
                    r.ctl = r.ctl | pia_pkg::FLAG_PIN2;
                r.line = 1'b1;
                r.fall = 1'b0;
                r.rise = 1'b0;
            end
            pia_pkg::MODE_IN_RISE, pia_pkg::MODE_IN_RISE_EN:
            begin
                if (!s.line || s.rise)
                    r.ctl = r.ctl | pia_pkg::FLAG_PIN2;
                r.line = 1'b1;
                r.fall = 1'b0;
                r.rise = 1'b0;
            end
            pia_pkg::MODE_HANDSHAKE:
            begin
                r.rise = 1'b0;
                r.ctl  = r.ctl & pia_pkg::CTL_WRITABLE;
            end
            pia_pkg::MODE_PULSE:
            begin
                r.line = 1'b1;
                r.ctl  = r.ctl & pia_pkg::CTL_WRITABLE;
                r.fall = 1'b0;
                r.rise = 1'b0;
            end
            pia_pkg::MODE_OUT_LOW:
            begin
                r.line = 1'b0;
                r.ctl  = r.ctl & pia_pkg::CTL_WRITABLE;
                r.fall = 1'b0;
                r.rise = 1'b0;
            end
            default:
            begin
                r.ctl = r.ctl & pia_pkg::CTL_WRITABLE;
                if (!s.line && (is_b || !s.fall))
                    r.rise = 1'b1;
                r.line = 1'b1;
                r.fall = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic side_t strobe_line(input side_t s);
        side_t r;
        r = s;
        if (s.ctl[5:3] == pia_pkg::MODE_HANDSHAKE)
        begin
            if (s.line)
                r.fall = 1'b1;
            r.line = 1'b0;
        end
        else if (s.ctl[5:3] == pia_pkg::MODE_PULSE)
        begin
            r.line = 1'b1;
        end
        return r;
    endfunction

    function automatic side_t pin_change(input side_t s, input logic v);
        side_t r;
        r = s;
        if (s.pin1 != v)
        begin
            if (v == s.ctl[pia_pkg::BIT_ENABLE])
                r.ctl = r.ctl | pia_pkg::FLAG_PIN1;
            r.pin1 = v;
        end
        return r;
    endfunction

    logic               xlxe_reg;
    side_t              side_a_reg, side_a_next;
    side_t              side_b_reg, side_b_next;
    logic [7:0]         output_a_reg, output_a_next;
    logic [7:0]         output_b_reg, output_b_next;
    logic [7:0]         mask_a_reg, mask_a_next;
    logic [7:0]         mask_b_reg, mask_b_next;
    logic               out_valid_reg;
    pia_pkg::out_item_t out_reg, out_next;
    pia_pkg::in_item_t  item;
    logic               in_fire;
    logic [7:0]         rd;
    logic               pulse_a, pulse_b;

    assign item        = in_ch.payload;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        side_a_next   = side_a_reg;
        side_b_next   = side_b_reg;
        output_a_next = output_a_reg;
        output_b_next = output_b_reg;
        mask_a_next   = mask_a_reg;
        mask_b_next   = mask_b_reg;
        rd            = 8'h00;
        pulse_a       = 1'b0;
        pulse_b       = 1'b0;
        case (item.opcode)
            pia_pkg::OP_READ:
            begin
                case (item.reg_select)
                    pia_pkg::SEL_PORT_A:
                    begin
                        if (!side_a_reg.ctl[pia_pkg::BIT_SELECT])
                            rd = ~mask_a_reg;
                        else
                        begin
                            if (!item.quiet_read)
                            begin
                                pulse_a         = side_a_reg.ctl[5:3] == pia_pkg::MODE_PULSE;
                                side_a_next     = strobe_line(side_a_reg);
                                side_a_next.ctl = side_a_reg.ctl & pia_pkg::CTL_WRITABLE;
                            end
                            rd = item.port_a_pins & (output_a_reg | mask_a_reg);
                        end
                    end
                    pia_pkg::SEL_PORT_B:
                    begin
                        if (!side_b_reg.ctl[pia_pkg::BIT_SELECT])
                            rd = ~mask_b_reg;
                        else
                        begin
                            if (!item.quiet_read)
                                side_b_next.ctl = side_b_reg.ctl & pia_pkg::CTL_WRITABLE;
                            if (xlxe_reg)
                                rd = output_b_reg | mask_b_reg;
                            else
                                rd = item.port_b_pins & (output_b_reg | mask_b_reg);
                        end
                    end
                    pia_pkg::SEL_CTL_A: rd = side_a_reg.ctl;
                    default:            rd = side_b_reg.ctl;
                endcase
            end
            pia_pkg::OP_WRITE:
            begin
                case (item.reg_select)
                    pia_pkg::SEL_PORT_A:
                    begin
                        if (!side_a_reg.ctl[pia_pkg::BIT_SELECT])
                            mask_a_next = ~item.write_data;
                        else
                            output_a_next = item.write_data;
                    end
                    pia_pkg::SEL_PORT_B:
                    begin
                        if (!side_b_reg.ctl[pia_pkg::BIT_SELECT])
                            mask_b_next = ~item.write_data;
                        else
                        begin
                            pulse_b       = side_b_reg.ctl[5:3] == pia_pkg::MODE_PULSE;
                            side_b_next   = strobe_line(side_b_reg);
                            output_b_next = item.write_data;
                        end
                    end
                    pia_pkg::SEL_CTL_A:
                        side_a_next = write_control(side_a_reg, item.write_data, 1'b0);
                    default:
                        side_b_next = write_control(side_b_reg, item.write_data, 1'b1);
                endcase
            end
            pia_pkg::OP_PIN_A: side_a_next = pin_change(side_a_reg, item.pin_level);
            default:           side_b_next = pin_change(side_b_reg, item.pin_level);
        endcase

        out_next.read_data    = rd;
        out_next.irq          = ctl_irq(side_a_next.ctl) | ctl_irq(side_b_next.ctl);
        out_next.ca2_level    = side_a_next.line;
        out_next.cb2_level    = side_b_next.line;
        out_next.ca2_pulse    = pulse_a;
        out_next.cb2_pulse    = pulse_b;
        out_next.port_a_drive = output_a_next | mask_a_next;
        out_next.port_b_drive = output_b_next | mask_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xlxe_reg      <= 1'b1;
            side_a_reg    <= SIDE_RESET;
            side_b_reg    <= SIDE_RESET;
            output_a_reg  <= pia_pkg::PORT_RESET;
            output_b_reg  <= pia_pkg::PORT_RESET;
            mask_a_reg    <= pia_pkg::PORT_RESET;
            mask_b_reg    <= pia_pkg::PORT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                xlxe_reg <= cfg_wr_data;
            if (in_fire)
            begin
                side_a_reg   <= side_a_next;
                side_b_reg   <= side_b_next;
                output_a_reg <= output_a_next;
                output_b_reg <= output_b_next;
                mask_a_reg   <= mask_a_next;
                mask_b_reg   <= mask_b_next;
            end
            if (in_ch.ready)
                out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_reg <= out_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    `PIA_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid_reg)
    `PIA_ASSERT_IMPLIES(a_pulse_ends_high, clk, rst_n, out_valid_reg && out_reg.ca2_pulse, out_reg.ca2_level)
    `PIA_ASSERT_NEXT(a_ctl_a_stable, clk, rst_n, !(in_fire && item.opcode == pia_pkg::OP_WRITE && item.reg_select == pia_pkg::SEL_CTL_A), $stable(side_a_reg.ctl[5:0]))

endmodule

`default_nettype wire
